FILE: sv/cfrb_pkg.sv
`timescale 1ns / 1ps

package cfrb_pkg;

    // Sizing
    localparam int BUF_BYTES  = 65536;
    localparam int READ_CHUNK = 32;
    localparam int MAX_CHUNKS = 32;
    localparam int CHUNK_MAX  = 1023;

    localparam int ADDR_W = $clog2(BUF_BYTES);
    localparam int CNT_W  = $clog2(BUF_BYTES + 1);
    localparam int IDX_W  = 5;
    localparam int SIZE_W = 10;
    localparam int LEN_W  = 6;
    localparam int MASK_W = MAX_CHUNKS;

    typedef enum logic [2:0] {
        FN_HDR      = 3'd0,
        FN_DATA     = 3'd1,
        FN_RD_FIRST = 3'd2,
        FN_RD_NEXT  = 3'd3,
        FN_ARM      = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_SEQ    = 3'd1,
        ST_TOO_BIG    = 3'd2,
        ST_BAD_END    = 3'd3,
        ST_NOT_READY  = 3'd4,
        ST_BAD_RD_SEQ = 3'd5,
        ST_RD_ERR     = 3'd6
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic cap;     // load input holding register
        logic exec;    // execute held item
        logic stream;  // emit one read byte
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic res;        // executed item gives a result beat
        logic go;         // read with bytes to stream
        logic last_byte;  // streaming the final byte
    } t_sts;

endpackage

FILE: sv/cfrb_ram.sv
`timescale 1ns / 1ps

module cfrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/cfrb_ctrl.sv
`timescale 1ns / 1ps

module cfrb_ctrl import cfrb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_in_valid, n_in_valid;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   load;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = r_in_valid;
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd.cap    = i_valid && !r_in_valid;
        o_cmd.exec   = 1'b0;
        o_cmd.stream = 1'b0;
        load         = 1'b0;
        n_in_valid   = r_in_valid || o_cmd.cap;
        unique case (r_state)
            S_IDLE: begin
                if (r_in_valid && out_free) begin
                    o_cmd.exec = 1'b1;
                    n_in_valid = 1'b0;
                    load       = i_sts.res;
                    if (i_sts.go) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (out_free) begin
                    o_cmd.stream = 1'b1;
                    load         = 1'b1;
                    if (i_sts.last_byte) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: sv/cfrb_dp.sv
`timescale 1ns / 1ps

module cfrb_dp import cfrb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [2:0]        i_func,
    input  logic [IDX_W-1:0]  i_chunk_index,
    input  logic [SIZE_W-1:0] i_chunk_size,
    input  logic              i_chunk_last,
    input  logic [7:0]        i_wr_data,
    output logic              o_kind,
    output logic [2:0]        o_status,
    output logic [LEN_W-1:0]  o_length,
    output logic              o_final_chunk,
    output logic [7:0]        o_rd_data,
    output logic              o_image_done,
    output logic              o_last
);

    // held input item
    logic [2:0]        r_func;
    logic [IDX_W-1:0]  r_idx;
    logic [SIZE_W-1:0] r_size;
    logic              r_clast;
    logic [7:0]        r_byte;

    // image state
    logic [CNT_W-1:0]  r_wc, n_wc;
    logic [CNT_W-1:0]  r_rc, n_rc;
    logic              r_busy, n_busy;
    logic              r_ready, n_ready;
    logic [IDX_W-1:0]  r_prev, n_prev;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic [SIZE_W-1:0] r_left, n_left;
    logic              r_open, n_open;
    logic              r_pend, n_pend;

    // read streaming
    logic [CNT_W-1:0]  r_rd_addr, n_rd_addr;
    logic [LEN_W-1:0]  r_rd_left, n_rd_left;

    // output payload
    logic              r_kind;
    t_status           r_st;
    logic [LEN_W-1:0]  r_len;
    logic              r_fin;
    logic [7:0]        r_data;
    logic              r_done;
    logic              r_last;

    // exec results
    t_status           st;
    logic              res, go, done, fin, we_c;
    logic [LEN_W-1:0]  len;

    logic              hdr_bad, too_big, busy_eff;
    logic [CNT_W-1:0]  wc_base, rc_eff, rest, rc_sum;
    logic [CNT_W:0]    wc_sum;
    logic [MASK_W-1:0] mask_set;
    logic [LEN_W-1:0]  rd_len;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_q;

    function automatic logic [MASK_W-1:0] want_mask(input logic [IDX_W-1:0] idx);
        logic [MASK_W:0] full;
        full = (MASK_W+1)'(1) << ({1'b0, idx} + 6'd1);
        return MASK_W'(full - (MASK_W+1)'(1));
    endfunction

    assign hdr_bad = ({1'b0, r_idx} >= (IDX_W+1)'(MAX_CHUNKS))
                  || (r_idx != '0 && {1'b0, r_idx} != {1'b0, r_prev} + (IDX_W+1)'(1));
    assign wc_base  = (r_idx == '0) ? '0 : r_wc;
    assign mask_set = (r_idx == '0) ? MASK_W'(1) : (r_mask | (MASK_W'(1) << r_idx));
    assign wc_sum   = {1'b0, wc_base} + (CNT_W+1)'(r_size);
    assign too_big  = ({2'b0, r_size} > (SIZE_W+2)'(CHUNK_MAX))
                   || (wc_sum > (CNT_W+1)'(BUF_BYTES));

    assign busy_eff = (r_func == FN_RD_FIRST) ? 1'b1 : r_busy;
    assign rc_eff   = (r_func == FN_RD_FIRST) ? '0 : r_rc;
    assign rest     = r_wc - rc_eff;
    assign fin      = rest <= CNT_W'(READ_CHUNK);
    assign rd_len   = fin ? rest[LEN_W-1:0] : LEN_W'(READ_CHUNK);
    assign rc_sum   = rc_eff + CNT_W'(rd_len);

    always_comb begin
        n_wc      = r_wc;
        n_rc      = r_rc;
        n_busy    = r_busy;
        n_ready   = r_ready;
        n_prev    = r_prev;
        n_mask    = r_mask;
        n_left    = r_left;
        n_open    = r_open;
        n_pend    = r_pend;
        res       = 1'b0;
        go        = 1'b0;
        st        = ST_OK;
        done      = 1'b0;
        len       = '0;
        we_c      = 1'b0;
        unique case (t_func'(r_func))
            FN_HDR: begin
                res    = 1'b1;
                n_open = 1'b0;
                n_left = '0;
                n_pend = 1'b0;
                if (hdr_bad) begin
                    n_mask = '0;
                    st     = ST_BAD_SEQ;
                end else begin
                    n_prev = r_idx;
                    n_wc   = wc_base;
                    n_mask = mask_set;
                    if (too_big) begin
                        n_mask = '0;
                        st     = ST_TOO_BIG;
                    end else if (r_size != '0) begin
                        n_open = 1'b1;
                        n_left = r_size;
                        n_pend = r_clast;
                    end else if (r_clast) begin
                        // empty last chunk closes at once
                        n_mask = '0;
                        if (mask_set == want_mask(r_idx)) begin
                            n_ready = 1'b1;
                            done    = 1'b1;
                        end else begin
                            st = ST_BAD_END;
                        end
                    end
                end
            end
            FN_DATA: begin
                if (r_open && r_left != '0) begin
                    if (r_wc < CNT_W'(BUF_BYTES)) begin
                        we_c = 1'b1;
                        n_wc = r_wc + CNT_W'(1);
                    end
                    n_left = r_left - SIZE_W'(1);
                    if (r_left == SIZE_W'(1)) begin
                        n_open = 1'b0;
                        if (r_pend) begin
                            res    = 1'b1;
                            n_pend = 1'b0;
                            n_mask = '0;
                            if (r_mask == want_mask(r_prev)) begin
                                n_ready = 1'b1;
                                done    = 1'b1;
                            end else begin
                                st = ST_BAD_END;
                            end
                        end
                    end
                end
            end
            FN_RD_FIRST, FN_RD_NEXT: begin
                res = 1'b1;
                if (!r_ready) begin
                    st = ST_NOT_READY;
                end else begin
                    n_busy = busy_eff;
                    n_rc   = rc_eff;
                    if (!busy_eff) begin
                        st = ST_BAD_RD_SEQ;
                    end else if (r_wc <= rc_eff) begin
                        st = ST_RD_ERR;
                    end else begin
                        go   = 1'b1;
                        len  = rd_len;
                        n_rc = rc_sum;
                        if (rc_sum >= r_wc) begin
                            n_busy  = 1'b0;
                            n_ready = 1'b0;
                        end
                    end
                end
            end
            FN_ARM: begin
                res     = 1'b1;
                n_ready = 1'b0;
            end
            default: ;
        endcase
    end

    // read address sequencing: first fetch at header, then one per byte beat
    always_comb begin
        n_rd_addr = r_rd_addr;
        n_rd_left = r_rd_left;
        ram_re    = 1'b0;
        ram_raddr = r_rd_addr[ADDR_W-1:0];
        if (i_cmd.exec && go) begin
            ram_re    = 1'b1;
            ram_raddr = rc_eff[ADDR_W-1:0];
            n_rd_addr = rc_eff + CNT_W'(1);
            n_rd_left = rd_len;
        end else if (i_cmd.stream) begin
            ram_re    = 1'b1;
            n_rd_addr = r_rd_addr + CNT_W'(1);
            n_rd_left = r_rd_left - LEN_W'(1);
        end
    end

    assign ram_we = i_cmd.exec && we_c;

    cfrb_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wc[ADDR_W-1:0]),
        .i_wdata (r_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc    <= '0;
            r_rc    <= '0;
            r_busy  <= 1'b0;
            r_ready <= 1'b0;
            r_prev  <= '0;
            r_mask  <= '0;
            r_left  <= '0;
            r_open  <= 1'b0;
            r_pend  <= 1'b0;
        end else if (i_cmd.exec) begin
            r_wc    <= n_wc;
            r_rc    <= n_rc;
            r_busy  <= n_busy;
            r_ready <= n_ready;
            r_prev  <= n_prev;
            r_mask  <= n_mask;
            r_left  <= n_left;
            r_open  <= n_open;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_left <= '0;
        end else begin
            r_rd_left <= n_rd_left;
        end
        r_rd_addr <= n_rd_addr;
        if (i_cmd.cap) begin
            r_func  <= i_func;
            r_idx   <= i_chunk_index;
            r_size  <= i_chunk_size;
            r_clast <= i_chunk_last;
            r_byte  <= i_wr_data;
        end
        if (i_cmd.exec) begin
            r_kind <= 1'b0;
            r_st   <= st;
            r_len  <= len;
            r_fin  <= go && fin;
            r_data <= '0;
            r_done <= done;
            r_last <= !go;
        end else if (i_cmd.stream) begin
            r_kind <= 1'b1;
            r_st   <= ST_OK;
            r_len  <= '0;
            r_fin  <= 1'b0;
            r_data <= ram_q;
            r_done <= 1'b0;
            r_last <= (r_rd_left == LEN_W'(1));
        end
    end

    assign o_sts.res       = res;
    assign o_sts.go        = go;
    assign o_sts.last_byte = (r_rd_left == LEN_W'(1));

    assign o_kind        = r_kind;
    assign o_status      = r_st;
    assign o_length      = r_len;
    assign o_final_chunk = r_fin;
    assign o_rd_data     = r_data;
    assign o_image_done  = r_done;
    assign o_last        = r_last;

endmodule

FILE: sv/chunked_frame_reassembly_buffer.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Beat payload
// input   | in        | i_valid / o_stall  | func, chunk_index, chunk_size, chunk_last, wr_data
// output  | out       | o_valid / i_stall  | kind, status, length, final_chunk, rd_data,
//         |           |                    |   image_done, last
//
// An input beat lands in a holding register, which stalls the input while it is held; the
// item executes once the output register is free, and its result beat is registered at that
// edge; headers, arm and reads give a result, a data byte only when it closes a last chunk.
// A good read gives its header, then one data beat per cycle while the output is not stalled,
// from the image RAM (registered read, prefetched one ahead); the next item waits held.
// Reset (synchronous, active low) clears control and counters, not the RAM; stalled beats hold.

module chunked_frame_reassembly_buffer import cfrb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_func,
    input  logic [IDX_W-1:0]  i_chunk_index,
    input  logic [SIZE_W-1:0] i_chunk_size,
    input  logic              i_chunk_last,
    input  logic [7:0]        i_wr_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_kind,
    output logic [2:0]        o_status,
    output logic [LEN_W-1:0]  o_length,
    output logic              o_final_chunk,
    output logic [7:0]        o_rd_data,
    output logic              o_image_done,
    output logic              o_last
);

    t_cmd cmd;
    t_sts sts;

    // sequencing: holding register, output register, read streaming state
    cfrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // image state, chunk checks, RAM and beat payload
    cfrb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (i_func),
        .i_chunk_index (i_chunk_index),
        .i_chunk_size  (i_chunk_size),
        .i_chunk_last  (i_chunk_last),
        .i_wr_data     (i_wr_data),
        .o_kind        (o_kind),
        .o_status      (o_status),
        .o_length      (o_length),
        .o_final_chunk (o_final_chunk),
        .o_rd_data     (o_rd_data),
        .o_image_done  (o_image_done),
        .o_last        (o_last)
    );

endmodule

FILE: sv/cfrb_chk.sv
`timescale 1ns / 1ps

module cfrb_chk import cfrb_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [2:0]        i_func,
    input logic [IDX_W-1:0]  i_chunk_index,
    input logic [SIZE_W-1:0] i_chunk_size,
    input logic              i_chunk_last,
    input logic [7:0]        i_wr_data,
    input logic              o_valid,
    input logic              i_stall,
    input logic              o_kind,
    input logic [2:0]        o_status,
    input logic [LEN_W-1:0]  o_length,
    input logic              o_final_chunk,
    input logic [7:0]        o_rd_data,
    input logic              o_image_done,
    input logic              o_last
);

    // data beats carry no status
    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_status == ST_OK && !o_image_done && o_length == '0)
        else $error("data beat with status fields");

    // completion only on a closing ok beat
    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_image_done |-> o_status == ST_OK && o_last && !o_kind)
        else $error("image_done on bad beat");

    // a read header with bytes never ends the item
    a_hdr_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind && o_length != '0 |-> !o_last && o_length <= LEN_W'(READ_CHUNK))
        else $error("bad read header");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rd_data) && $stable(o_last))
        else $error("stalled beat changed");

endmodule

bind chunked_frame_reassembly_buffer cfrb_chk u_cfrb_chk (.*);
